>>> src/vn3b_pkg.sv
// Package for the three-band value noise block: constants and arithmetic helpers.
// Used by every module under src except vn3b_if; no dependencies.
`timescale 1ns / 1ps
package vn3b_pkg;

	localparam int unsigned PosW  = 24;
	localparam int unsigned FreqW = 24;
	localparam int unsigned SeedW = 32;
	localparam int unsigned GrainW = 16;
	localparam int unsigned RegIdxW = 1;

	// register indexes
	localparam logic [RegIdxW-1:0] RegBaseFreq  = 1'd0;
	localparam logic [RegIdxW-1:0] RegNoiseSeed = 1'd1;

	localparam logic [23:0] FreqReset = 24'd65536;
	localparam logic [31:0] SeedReset = 32'd1;

	// rotation coefficients, Q0.16
	localparam logic signed [17:0] C80 = 18'sd52429;
	localparam logic signed [17:0] C60 = 18'sd39322;
	localparam logic signed [17:0] C28 = 18'sd18350;
	localparam logic signed [17:0] C96 = 18'sd62915;

	localparam logic [18:0] F2Mul = 19'd135660;
	localparam logic [18:0] F3Mul = 19'd282460;
	localparam logic [15:0] W1 = 16'd36045;
	localparam logic [15:0] W2 = 16'd19661;
	localparam logic [15:0] W3 = 16'd9830;
	localparam logic [31:0] Seed2Xor = 32'h51;
	localparam logic [31:0] Seed3Xor = 32'hA3;

	localparam logic [31:0] HashX = 32'h9E3779B9;
	localparam logic [31:0] HashY = 32'h85EBCA77;
	localparam logic [31:0] HashZ = 32'hC2B2AE3D;
	localparam logic [31:0] MixA  = 32'h7feb352d;
	localparam logic [31:0] MixB  = 32'h846ca68b;

	// first half of lowbias32: xor-shift and first multiply
	function automatic logic [31:0] mix_a(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v >> 16);
		return t * MixA;
	endfunction

	// second half of lowbias32
	function automatic logic [31:0] mix_b(input logic [31:0] v);
		logic [31:0] t;
		logic [31:0] u;
		t = v ^ (v >> 15);
		u = t * MixB;
		return u ^ (u >> 16);
	endfunction

	// band coordinate format after rotation (grows by one bit per turn)
	localparam int unsigned CoordW = 26;
	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic [31:0] cell_t;
	typedef logic [15:0] frac_t;
	typedef logic [23:0] val_t;

endpackage

>>> src/vn3b_if.sv
// Valid/ready channel interface carrying one item payload.
// Depends on nothing; payload type given as parameter.
`timescale 1ns / 1ps
interface vn3b_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/value_noise_three_band.sv
// Three-band value noise: result valid after 18 register stages, throughput one
// item per cycle while the output is not stalled, as the band units are fully
// pipelined.
// The pipeline advances whenever the output stage is empty or being taken.
// Reset clears valid bits and sets base_freq to 1.0 and noise_seed to 1.
`timescale 1ns / 1ps
module value_noise_three_band
	import vn3b_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [RegIdxW-1:0] cfg_idx,
	input  logic [31:0] cfg_data,
	vn3b_if.sink   pin,
	vn3b_if.source pout
);
	localparam int unsigned Lat = 17;
	logic [23:0] freq_q;
	logic [31:0] seed_q;
	logic [31:0] f1, f2, f3;
	logic [Lat-1:0] vld_q;
	logic en;
	coord_t p0 [3];
	coord_t p1 [3];
	coord_t p2 [3];
	val_t v1, v2, v3;
	logic [47:0] sum_s17;
	logic [15:0] grain_q;
	logic out_v_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FreqReset;
			seed_q <= SeedReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegBaseFreq:  freq_q <= cfg_data[23:0];
				RegNoiseSeed: seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign f1 = 32'(freq_q);
	assign f2 = 32'((43'(freq_q) * 43'(F2Mul)) >> 16);
	assign f3 = 32'((43'(freq_q) * 43'(F3Mul)) >> 16);

	// advance when the output register is free or being taken
	assign en = !out_v_q || pout.ready;
	assign pin.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[Lat-2:0], pin.valid};
			out_v_q <= vld_q[Lat-1];
		end
	end

	vn3b_rot u_rot (
		.clk(clk), .en(en),
		.px(pin.data.pos_x), .py(pin.data.pos_y), .pz(pin.data.pos_z),
		.p0(p0), .p1(p1), .p2(p2)
	);

	vn3b_band u_b1 (.clk(clk), .en(en), .p(p0), .freq(f1), .seed(seed_q), .val(v1));
	vn3b_band u_b2 (.clk(clk), .en(en), .p(p1), .freq(f2),
		.seed(seed_q ^ Seed2Xor), .val(v2));
	vn3b_band u_b3 (.clk(clk), .en(en), .p(p2), .freq(f3),
		.seed(seed_q ^ Seed3Xor), .val(v3));

	// weight and sum bands
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s17 <= 48'(v1 * W1) + 48'(v2 * W2) + 48'(v3 * W3);
			grain_q <= sum_s17[39:24];
		end
	end

	assign pout.valid = out_v_q;
	assign pout.data.grain = grain_q;

	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		pout.valid && !pout.ready |=> $stable(pout.data.grain))
		else $error("result changed during stall");
	// ready only drops while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		!pin.ready |-> pout.valid)
		else $error("input stalled with empty output");
	// an item accepted while the output is empty is registered into the first valid bit
	assert property (@(posedge clk) disable iff (!arst_n)
		!pout.valid && pin.valid |=> vld_q[0])
		else $error("accepted item lost");
endmodule

>>> src/vn3b_rot.sv
// Rotation stages: turns the point about y, then about x, registered in stages s1 to s3.
// Depends on vn3b_pkg.
`timescale 1ns / 1ps
module vn3b_rot
	import vn3b_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  logic signed [PosW-1:0] px,
	input  logic signed [PosW-1:0] py,
	input  logic signed [PosW-1:0] pz,
	output coord_t p0 [3],
	output coord_t p1 [3],
	output coord_t p2 [3]
);
	logic signed [PosW-1:0] px_s1, py_s1, pz_s1;
	logic signed [43:0] axm_s1, azm_s1;
	coord_t ax, az;
	coord_t q0_s2 [3];
	coord_t q1_s2 [3];
	logic signed [45:0] bym_s2, bzm_s2;
	coord_t by, bz;
	coord_t r0_s3 [3];
	coord_t r1_s3 [3];
	coord_t r2_s3 [3];

	// turn about y; arithmetic shift floors
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px;
			py_s1 <= py;
			pz_s1 <= pz;
			axm_s1 <= 44'(px * C80) - 44'(pz * C60);
			azm_s1 <= 44'(px * C60) + 44'(pz * C80);
		end
	end
	assign ax = coord_t'(axm_s1 >>> 16);
	assign az = coord_t'(azm_s1 >>> 16);

	// turn about x
	always_ff @(posedge clk) begin
		if (en) begin
			q0_s2[0] <= coord_t'(px_s1);
			q0_s2[1] <= coord_t'(py_s1);
			q0_s2[2] <= coord_t'(pz_s1);
			q1_s2[0] <= ax;
			q1_s2[1] <= coord_t'(py_s1);
			q1_s2[2] <= az;
			bym_s2 <= 46'(coord_t'(py_s1) * C28) - 46'(az * C96);
			bzm_s2 <= 46'(coord_t'(py_s1) * C96) + 46'(az * C28);
		end
	end
	assign by = coord_t'(bym_s2 >>> 16);
	assign bz = coord_t'(bzm_s2 >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s3 <= q0_s2;
			r1_s3 <= q1_s2;
			r2_s3[0] <= q1_s2[0];
			r2_s3[1] <= by;
			r2_s3[2] <= bz;
		end
	end
	assign p0 = r0_s3;
	assign p1 = r1_s3;
	assign p2 = r2_s3;
endmodule

>>> src/vn3b_band.sv
// One noise band: scale, smoothstep, corner hashing and trilinear blend.
// Fully pipelined; depends on vn3b_pkg.
`timescale 1ns / 1ps
module vn3b_band
	import vn3b_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  coord_t      p [3],
	input  logic [31:0] freq,
	input  logic [31:0] seed,
	output val_t        val
);
	// stage 1: sample coordinate product, Q.32
	logic signed [63:0] c_s1 [3];
	// stage 2: cell, fraction squared
	cell_t cell_s2 [3];
	frac_t t_s2 [3];
	logic [31:0] tt_s2 [3];
	// stage 3: smoothstep
	frac_t s_s3 [3];
	cell_t cell_s3 [3];
	frac_t s_s4 [3];
	frac_t s_s5 [3];
	frac_t s_s6 [3];
	frac_t s_s7 [3];
	frac_t s_s8 [3];
	frac_t s_s9 [3];
	// hash chain per axis and corner side
	logic [31:0] hy_s4 [2];
	logic [31:0] hz_s4 [2];
	logic [31:0] hx_s4 [2];
	logic [31:0] my_s5 [2];
	logic [31:0] mz_s5 [2];
	logic [31:0] hx_s5 [2];
	logic [31:0] in_s6 [8];
	logic [31:0] ia_s7 [8];
	logic [31:0] ib_s8 [8];
	logic [31:0] oa_s9 [8];
	val_t cv_s10 [8];
	frac_t s_s10 [3];
	val_t l1_s11 [4];
	frac_t s_s11 [2];
	val_t l2_s12 [2];
	frac_t s_s12;
	val_t l3_s13;
	logic [31:0] seed_d [7];

	function automatic val_t lerp(input val_t a, input val_t b, input frac_t s);
		logic signed [41:0] d;
		d = (42'($signed({1'b0, b})) - 42'($signed({1'b0, a}))) * $signed({1'b0, s});
		return val_t'(42'($signed({1'b0, a})) + (d >>> 16));
	endfunction

	// seed travels alongside items so it matches the stage
	always_ff @(posedge clk) begin
		if (en) begin
			seed_d[0] <= seed;
			for (int i = 1; i < 7; i++) seed_d[i] <= seed_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s1[i] <= 64'(p[i]) * $signed({32'd0, freq});
				cell_s2[i] <= c_s1[i][63:32];
				t_s2[i] <= c_s1[i][31:16];
				tt_s2[i] <= c_s1[i][31:16] * c_s1[i][31:16];
				cell_s3[i] <= cell_s2[i];
				s_s3[i] <= frac_t'((49'(tt_s2[i]) * (49'(18'd196608) - 49'({t_s2[i], 1'b0})))
					>> 32);
				s_s4[i] <= s_s3[i];
				s_s5[i] <= s_s4[i];
				s_s6[i] <= s_s5[i];
				s_s7[i] <= s_s6[i];
				s_s8[i] <= s_s7[i];
				s_s9[i] <= s_s8[i];
				s_s10[i] <= s_s9[i];
			end
		end
	end

	// axis hashes: premultiply, then mix halves for y and z
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				hx_s4[k] <= (cell_s3[0] + 32'(k)) * HashX;
				hy_s4[k] <= (cell_s3[1] + 32'(k)) * HashY;
				hz_s4[k] <= (cell_s3[2] + 32'(k)) * HashZ;
				my_s5[k] <= mix_a(hy_s4[k]);
				mz_s5[k] <= mix_a(hz_s4[k]);
				hx_s5[k] <= hx_s4[k];
			end
			// corner index bit0 = x, bit1 = y, bit2 = z
			for (int c = 0; c < 8; c++) begin
				in_s6[c] <= hx_s5[c & 1] ^ mix_b(my_s5[(c >> 1) & 1])
					^ mix_b(mz_s5[(c >> 2) & 1]);
				ia_s7[c] <= mix_a(in_s6[c]);
				ib_s8[c] <= seed_d[6] ^ mix_b(ia_s7[c]);
				oa_s9[c] <= mix_a(ib_s8[c]);
				cv_s10[c] <= val_t'(mix_b(oa_s9[c]) >> 8);
			end
		end
	end

	// trilinear blend, x then y then z
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++)
				l1_s11[j] <= lerp(cv_s10[2*j], cv_s10[2*j+1], s_s10[0]);
			s_s11[0] <= s_s10[1];
			s_s11[1] <= s_s10[2];
			l2_s12[0] <= lerp(l1_s11[0], l1_s11[1], s_s11[0]);
			l2_s12[1] <= lerp(l1_s11[2], l1_s11[3], s_s11[0]);
			s_s12 <= s_s11[1];
			l3_s13 <= lerp(l2_s12[0], l2_s12[1], s_s12);
		end
	end
	assign val = l3_s13;
endmodule
